FILE: src/sntdw_pkg.sv
// Package for the signed number to digit-register write block.
// Holds the sequencer states, cell control type, register indexes and segment codes.
// No dependencies.
package sntdw_pkg;

    // Number of decimal digit cells; 2147483647 has ten digits.
    localparam int NUM_CELLS  = 10;
    // Shift steps of the conversion; the saturated magnitude has 31 bits.
    localparam int CONV_STEPS = 31;
    localparam int MAG_W      = 31;

    // Configuration register indexes.
    localparam logic REG_ALIGN_MODE   = 1'b0;
    localparam logic REG_MINUS_ENABLE = 1'b1;

    // Special segment codes.
    localparam logic [7:0] MINUS_CODE = 8'h01;
    localparam logic [7:0] DP_BIT     = 8'h80;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT,
        S_FLUSH
    } t_state;

    // Control shared by all digit cells.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    // Segment pattern of one decimal digit, bits 6..0 are segments a..g.
    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] code;
        unique case (d)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

FILE: src/signed_number_to_digit_writes.sv
// Top level: converts a signed number into seven-segment digit-register writes.
// Depends on sntdw_pkg and sntdw_cell.
//
// Usage:
// An input request (i_in_valid / o_in_ready) carries a signed number, a device
// index, a start position and a decimal-point position. The block answers with
// zero to eight write requests on the output channel (o_out_valid / i_out_ready),
// each holding device, digit address 1..8 and segment byte; o_last marks the
// final write of a request. Writes that would land outside addresses 1..8 are
// dropped, and a device index not below MAX_DEVICES gives no writes.
// Timing: one request is worked at a time. The magnitude passes through a row
// of ten decimal digit cells, one bit per cycle, then one write slot (up to
// eleven) is visited per cycle while the receiver takes writes, and a flush
// state releases the last write.
// A one-entry hold stage and the output register let the last write of one
// request wait while the next request is taken. A stalled receiver holds the
// write slots in place; nothing is lost.
// Reset (synchronous, active low) returns to idle, clears the output valid and
// sets align_mode to 0 and minus_enable to 1. i_cfg_we writes a register at once.
module signed_number_to_digit_writes
    import sntdw_pkg::*;
#(
    parameter int MAX_DEVICES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_number,
    input  logic [2:0]  i_device,
    input  logic [3:0]  i_start_position,
    input  logic [3:0]  i_dp_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_out_device,
    output logic [3:0]  o_digit_address,
    output logic [7:0]  o_segments,
    output logic        o_last
);

    t_state r_state, n_state;

    logic              r_align, r_minus_en;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [2:0]        r_dev;
    logic [3:0]        r_start, r_dp;
    logic [4:0]        r_bit;
    logic [3:0]        r_slot;
    logic              r_hold_valid;
    logic [3:0]        r_hold_addr;
    logic [7:0]        r_hold_seg;
    logic              r_out_valid;
    logic [2:0]        r_out_dev;
    logic [3:0]        r_out_addr;
    logic [7:0]        r_out_seg;
    logic              r_out_last;

    logic              w_accept, w_dev_ok, w_out_free;
    logic [31:0]       w_mag32;
    logic [MAG_W-1:0]  w_mag_sat;
    t_cell_ctrl        w_ctl;
    logic [NUM_CELLS-1:0] w_carry;
    logic [3:0]        w_digit [NUM_CELLS];
    logic [3:0]        w_nd, w_total, w_k;
    logic              w_zero, w_minus_on, w_is_digit, w_dp_hit, w_in_range;
    logic signed [6:0] w_addr;
    logic [7:0]        w_seg;
    logic              w_advance, w_hold_load, w_out_load, w_out_last, w_last_slot;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_dev_ok   = (32'(i_device) < MAX_DEVICES);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Magnitude with saturation of the most negative number.
    assign w_mag32   = i_number[31] ? (32'd0 - i_number) : i_number;
    assign w_mag_sat = w_mag32[31] ? {MAG_W{1'b1}} : w_mag32[MAG_W-1:0];

    // Row of decimal digit cells; the magnitude enters cell 0 msb first.
    assign w_carry[0] = r_mag[MAG_W-1];
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g < NUM_CELLS - 1) begin : g_mid
            sntdw_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_carry (w_carry[g]),
                .o_carry (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end else begin : g_top
            sntdw_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_carry (w_carry[g]),
                .o_carry (),
                .o_digit (w_digit[g])
            );
        end
    end

    // Digit count: position of the highest nonzero cell plus one.
    always_comb begin
        w_nd = 4'd0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (w_digit[i] != 4'd0) begin
                w_nd = 4'(i + 1);
            end
        end
    end

    assign w_zero      = (w_nd == 4'd0);
    assign w_minus_on  = r_neg && r_minus_en && !w_zero;
    assign w_total     = w_zero ? 4'd1 : (w_nd + {3'd0, w_minus_on});
    assign w_last_slot = (r_slot == (w_total - 4'd1));

    // Address, digit index and segment byte of the current write slot.
    always_comb begin
        if (!r_align) begin
            w_addr     = 7'sd9 - $signed({3'd0, r_start}) - $signed({3'd0, r_slot});
            w_is_digit = w_zero || (r_slot < w_nd);
            w_k        = r_slot;
            w_dp_hit   = (r_dp != 4'd0) && (w_k == r_dp);
        end else begin
            w_addr     = $signed({3'd0, r_start}) + $signed({3'd0, r_slot});
            w_is_digit = !(w_minus_on && (r_slot == 4'd0));
            if (w_zero) begin
                w_k = 4'd0;
            end else if (w_minus_on) begin
                w_k = w_nd - r_slot;
            end else begin
                w_k = w_nd - 4'd1 - r_slot;
            end
            w_dp_hit = !w_zero && ((5'(r_slot) + 5'd1) == {1'b0, r_dp});
        end
        if (w_is_digit) begin
            w_seg = digit_code(w_digit[w_k]) | (w_dp_hit ? DP_BIT : 8'h00);
        end else begin
            w_seg = MINUS_CODE;
        end
        w_in_range = (w_addr >= 7'sd1) && (w_addr <= 7'sd8);
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_dev_ok ? S_CONV : S_FLUSH;
                end
            end
            S_CONV: begin
                if (r_bit == 5'(CONV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_advance && w_last_slot) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        o_in_ready  = 1'b0;
        w_ctl       = '0;
        w_advance   = 1'b0;
        w_hold_load = 1'b0;
        w_out_load  = 1'b0;
        w_out_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.clear = w_accept;
            end
            S_CONV: begin
                w_ctl.shift = 1'b1;
            end
            S_EMIT: begin
                w_advance = !r_hold_valid || w_out_free;
                w_hold_load = w_advance && w_in_range;
                w_out_load = w_hold_load && r_hold_valid;
            end
            S_FLUSH: begin
                w_out_load = r_hold_valid && w_out_free;
                w_out_last = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_align      <= 1'b0;
            r_minus_en   <= 1'b1;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ALIGN_MODE:   r_align    <= i_cfg_data;
                    REG_MINUS_ENABLE: r_minus_en <= i_cfg_data;
                    default:          r_align    <= r_align;
                endcase
            end
            if (w_hold_load) begin
                r_hold_valid <= 1'b1;
            end else if (w_out_load) begin
                r_hold_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, conversion counters and write payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag   <= w_mag_sat;
            r_neg   <= i_number[31];
            r_dev   <= i_device;
            r_start <= i_start_position;
            r_dp    <= i_dp_position;
            r_bit   <= 5'd0;
            r_slot  <= 4'd0;
        end else if (r_state == S_CONV) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_bit <= r_bit + 5'd1;
        end else if (w_advance) begin
            r_slot <= r_slot + 4'd1;
        end
        if (w_hold_load) begin
            r_hold_addr <= w_addr[3:0];
            r_hold_seg  <= w_seg;
        end
        if (w_out_load) begin
            r_out_dev  <= r_dev;
            r_out_addr <= r_hold_addr;
            r_out_seg  <= r_hold_seg;
            r_out_last <= w_out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_device    = r_out_dev;
    assign o_digit_address = r_out_addr;
    assign o_segments      = r_out_seg;
    assign o_last          = r_out_last;

endmodule

FILE: src/sntdw_cell.sv
// One decimal digit cell of the shift-and-add-3 binary to decimal converter.
// Depends on sntdw_pkg for the cell control type.
module sntdw_cell
    import sntdw_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctl,
    input  logic       i_carry,
    output logic       o_carry,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_adj;

    // Add three to digits of five or more before the shift.
    always_comb begin
        n_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    assign o_carry = n_adj[3];
    assign o_digit = r_digit;

    // Shift one bit in from the lower neighbor, the top bit goes to the upper one.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.shift) begin
            r_digit <= {n_adj[2:0], i_carry};
        end
    end

endmodule

FILE: src/sntdw_checker.sv
// Port-level checker for signed_number_to_digit_writes, attached by bind.
// Depends only on the top level's ports.
module sntdw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_out_device,
    input logic [3:0]  o_digit_address,
    input logic [7:0]  o_segments,
    input logic        o_last
);

    // A stalled write request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_device)
            && $stable(o_digit_address) && $stable(o_segments) && $stable(o_last))
        else $error("stalled write request changed");

    // Every write lands on a digit register of the device.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_address >= 4'd1) && (o_digit_address <= 4'd8))
        else $error("digit address out of range");

    // While writes of a request are still to come, no new request is taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken before the last write");

    // A taken request occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request was taken");

endmodule

bind signed_number_to_digit_writes sntdw_checker u_sntdw_checker (.*);
